// ===== rtl/ftma_pkg.sv =====
`default_nettype none

package ftma_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 24;
	localparam int WLEN_W     = 7;
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int SUM_W      = SAMPLE_W + SLOT_W;
	localparam int DIV_W      = SUM_W;
	localparam int DIVISOR_W  = SAMPLE_W;
	localparam int DIV_STEPS  = DIV_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [WLEN_W-1:0]   WLEN_RESET = WLEN_W'(64);
	localparam logic [SAMPLE_W-1:0] RATE_MAX   = {SAMPLE_W{1'b1}};
	localparam logic [DIV_W-1:0]    RATE_NUM   = DIV_W'(1) << SAMPLE_W;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// 0 acts as 1, anything above the ring depth acts as the depth
	function automatic logic [WLEN_W-1:0] eff_len(input logic [WLEN_W-1:0] wl);
		logic [WLEN_W-1:0] r;
		if (wl == '0) begin
			r = WLEN_W'(1);
		end else if (wl > WLEN_W'(MAX_WINDOW)) begin
			r = WLEN_W'(MAX_WINDOW);
		end else begin
			r = wl;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ftma_div.sv =====
`default_nettype none

module ftma_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ftma_pkg::DIV_W-1:0]     dividend,
	input  wire logic [ftma_pkg::DIVISOR_W-1:0] divisor,
	output ftma_pkg::div_stat_t                 stat,
	output logic [ftma_pkg::DIV_W-1:0]          quotient
);
	import ftma_pkg::*;

	// restoring radix-2, one quotient bit per cycle
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   trial;
	logic                 fits;
	logic [DIVISOR_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/ftma_ring.sv =====
`default_nettype none

module ftma_ring (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clr,
	input  wire logic                          rd_en,
	input  wire logic [ftma_pkg::SLOT_W-1:0]   rd_addr,
	output logic [ftma_pkg::SAMPLE_W-1:0]      rd_data,
	input  wire logic                          wr_en,
	input  wire logic [ftma_pkg::SLOT_W-1:0]   wr_addr,
	input  wire logic [ftma_pkg::SAMPLE_W-1:0] wr_data
);
	import ftma_pkg::*;

	logic [SAMPLE_W-1:0]   mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] valid_q;
	logic [SAMPLE_W-1:0]   rd_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/frame_time_moving_average_core.sv =====
// Frame-time moving average over a ring of window_length samples.
//
// s_tvalid/s_tready/s_tdata takes one frame-time word (unsigned Q4.20 s).
// m_tvalid/m_tready/m_tdata/m_tuser returns one word per sample: the mean
// of the last window_length samples and 2^24 / mean (1/16 fps), with
// m_tuser flagging a clamped rate (mean of 0 or 1).
// cfg_valid/cfg_ready/cfg_data writes window_length (0 acts as 1, above 64
// acts as 64); every write clears the history. Write only while idle.
//
// From accept to m_tvalid a sample goes through one ring read, one sum
// update, then two 30-step passes through the shared radix-2 divider
// (sum / length, then 2^24 / mean). A clamped rate skips the second pass.
// s_tready is high only between samples, so a new sample is accepted
// only once the last result has been passed to the output register.
// The result sits in an output register: the next sample is accepted
// while it waits, and the block holds its finished result until m_tready.
// Reset clears the ring (per-entry valid bits), the slot, the running sum,
// and sets window_length to 64; no sweep is needed.
`default_nettype none

module frame_time_moving_average_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [23:0] frame_time
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [23:0] average_time, [47:24] frame_rate
	output logic             m_tuser,   // [0] rate_saturated
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data   // [6:0] window_length
);
	import ftma_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_AVG  = 3'd2;
	localparam logic [2:0] S_RATE = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [WLEN_W-1:0]   wlen_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [SAMPLE_W-1:0] rate_q;
	logic                sat_q;
	logic                ovalid_q;
	logic [SAMPLE_W-1:0] oavg_q;
	logic [SAMPLE_W-1:0] orate_q;
	logic                osat_q;

	logic [WLEN_W-1:0]   len;
	logic [SLOT_W-1:0]   slot_eff;
	logic [WLEN_W-1:0]   slot_inc;
	logic [SLOT_W-1:0]   slot_next;
	logic [SAMPLE_W-1:0] old;
	logic [SUM_W-1:0]    sum_next;
	logic                in_acc;
	logic                cfg_acc;
	logic                out_free;

	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [DIVISOR_W-1:0] div_divisor;
	div_stat_t           div_stat;
	logic [DIV_W-1:0]    div_quo;
	logic [SAMPLE_W-1:0] quo_lo;

	assign len       = eff_len(wlen_q);
	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !ovalid_q || m_tready;
	assign quo_lo    = div_quo[SAMPLE_W-1:0];

	always_comb begin
		slot_eff  = ({1'b0, slot_q} >= len) ? '0 : slot_q;
		slot_inc  = {1'b0, cur_q} + WLEN_W'(1);
		slot_next = (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
		sum_next  = sum_q - SUM_W'(old) + SUM_W'(sample_q);
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = sum_next;
		div_divisor  = DIVISOR_W'(len);
		unique case (state_q)
			S_READ: begin
				div_start = 1'b1;
			end
			S_AVG: begin
				div_dividend = RATE_NUM;
				div_divisor  = quo_lo;
				div_start    = div_stat.done && (quo_lo > SAMPLE_W'(1));
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	ftma_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_acc),
		.rd_en   (in_acc),
		.rd_addr (slot_eff),
		.rd_data (old),
		.wr_en   (state_q == S_READ),
		.wr_addr (cur_q),
		.wr_data (sample_q)
	);

	ftma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wlen_q   <= WLEN_RESET;
			slot_q   <= '0;
			sum_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					sum_q   <= sum_next;
					slot_q  <= slot_next;
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (div_stat.done) begin
						state_q <= (quo_lo > SAMPLE_W'(1)) ? S_RATE : S_OUT;
					end
				end
				S_RATE: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_acc) begin
				wlen_q <= cfg_data;
				slot_q <= '0;
				sum_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= s_tdata[SAMPLE_W-1:0];
			cur_q    <= slot_eff;
		end
		if (state_q == S_AVG && div_stat.done) begin
			avg_q  <= quo_lo;
			rate_q <= RATE_MAX;
			sat_q  <= (quo_lo <= SAMPLE_W'(1));
		end
		if (state_q == S_RATE && div_stat.done) begin
			rate_q <= quo_lo;
		end
		if (state_q == S_OUT && out_free) begin
			oavg_q  <= avg_q;
			orate_q <= rate_q;
			osat_q  <= sat_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {orate_q, oavg_q};
	assign m_tuser  = osat_q;

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_stat.busy)
		else $error("divider busy while idle");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < len)
		else $error("write slot outside window");

	a_sat_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:24] == RATE_MAX)
		else $error("saturated flag without clamped rate");

	a_unsat_avg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[23:0] > 24'd1)
		else $error("unclamped rate from tiny average");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && !out_free |=> state_q == S_OUT)
		else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== sim/frame_time_moving_average_core_tb.sv =====
`timescale 1ns / 1ps

module frame_time_moving_average_core_tb;

	import ftma_pkg::MAX_WINDOW;
	import ftma_pkg::RATE_MAX;
	import ftma_pkg::WLEN_RESET;

	localparam int HOLD_CYCLES = 700;

	typedef struct {
		logic [23:0] average_time;
		logic [23:0] frame_rate;
		logic        rate_saturated;
	} frame_stats_t;

	class frame_rate_board;
		logic [23:0]     ring [MAX_WINDOW];
		int unsigned     slot;
		longint unsigned total;
		logic [6:0]      wlen;
		frame_stats_t    pending [$];
		int              errors;
		int              results;
		int              clamped;

		function new();
			wlen    = WLEN_RESET;
			errors  = 0;
			results = 0;
			clamped = 0;
			clear();
		endfunction

		function void clear();
			foreach (ring[i]) ring[i] = '0;
			slot  = 0;
			total = 0;
		endfunction

		function void set_length(input logic [6:0] v);
			wlen = v;
			clear();
		endfunction

		function int unsigned span();
			if (wlen == 0)
				return 1;
			if (wlen > MAX_WINDOW)
				return MAX_WINDOW;
			return wlen;
		endfunction

		function void add_sample(input logic [23:0] ft);
			int unsigned     len;
			int unsigned     s;
			longint unsigned mean;
			frame_stats_t    e;
			len = span();
			s   = slot;
			if (s >= len)
				s = 0;
			total   = total - ring[s] + ft;
			ring[s] = ft;
			s++;
			if (s >= len)
				s = 0;
			slot = s;
			mean = total / len;
			e.average_time = mean[23:0];
			if (e.average_time <= 24'd1) begin
				e.frame_rate     = RATE_MAX;
				e.rate_saturated = 1'b1;
			end else begin
				e.frame_rate     = 24'(32'h0100_0000 / {8'd0, e.average_time});
				e.rate_saturated = 1'b0;
			end
			pending.push_back(e);
		endfunction

		function void check_stats(input logic [23:0] avg, input logic [23:0] rate,
				input logic sat);
			frame_stats_t e;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: avg %0d rate %0d sat %0d",
					avg, rate, sat);
				errors++;
				return;
			end
			e = pending.pop_front();
			results++;
			if (sat)
				clamped++;
			if (avg !== e.average_time) begin
				$error("average_time: expected %0d, got %0d", e.average_time, avg);
				errors++;
			end
			if (rate !== e.frame_rate) begin
				$error("frame_rate: expected %0d, got %0d", e.frame_rate, rate);
				errors++;
			end
			if (sat !== e.rate_saturated) begin
				$error("rate_saturated: expected %0d, got %0d", e.rate_saturated, sat);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	frame_rate_board board = new();

	bit          no_idle      = 1'b0;
	bit          hold_request = 1'b0;
	int          holds_done   = 0;
	int          samples_sent = 0;
	int          length_writes = 0;
	logic [23:0] frame_base   = 24'd17476;

	frame_time_moving_average_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 24);
		return $urandom_range(60, 200);
	endfunction

	function automatic logic [23:0] next_frame_time();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 24'($urandom_range(0, 3));
		if (r == 1)
			return 24'hFF_FFFF - 24'($urandom_range(0, 3));
		if (r < 9)
			return frame_base ^ 24'($urandom_range(0, 255));
		return 24'($urandom);
	endfunction

	// called at a falling edge; returns at a falling edge with s_tvalid still high
	task automatic send_sample(input logic [23:0] ft);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = ft;
		do @(posedge clk); while (!s_tready);
		board.add_sample(ft);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic write_length(input logic [6:0] v);
		s_tvalid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		board.set_length(v);
		length_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_stats(m_tdata[23:0], m_tdata[47:24], m_tuser);
	end

	// output side: random back-pressure, plus one long stall on request
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			n = idle_len();
			if (n > 0) begin
				m_tready = 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready = 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	initial begin
		logic [6:0] plan [6];
		logic [6:0] len;
		plan = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd0, 7'd63};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset length, mostly empty window
		send_sample(24'h00_0000);
		send_sample(24'hFF_FFFF);
		send_sample(24'hFF_FFFF);
		send_sample(24'h00_0001);

		// single-entry window: zero and tiny means clamp, exact reciprocals
		write_length(7'd1);
		send_sample(24'h00_0000);
		send_sample(24'h00_0001);
		send_sample(24'h00_0002);
		send_sample(24'h00_0003);
		send_sample(24'hFF_FFFF);
		send_sample(24'h80_0000);
		send_sample(24'h80_0001);
		send_sample(24'h55_5555);
		send_sample(24'hAA_AAAA);

		// zero length acts as one
		write_length(7'd0);
		send_sample(24'h00_0002);
		send_sample(24'h00_0000);

		// two entries: wrap and truncated mean
		write_length(7'd2);
		send_sample(24'hFF_FFFF);
		send_sample(24'hFF_FFFF);
		send_sample(24'hFF_FFFF);
		send_sample(24'h00_0001);
		send_sample(24'h00_0003);

		// oversized lengths act as the ring depth
		write_length(7'd127);
		send_sample(24'h00_0080);
		send_sample(24'hFF_FFFF);
		write_length(7'd65);
		send_sample(24'h12_3456);

		for (int p = 0; p < 13; p++) begin
			len = (p < 6) ? plan[p] : 7'($urandom_range(0, 127));
			write_length(len);
			no_idle    = (p % 4 == 2);
			frame_base = (p % 2 == 0) ? 24'($urandom_range(1000, 300000))
				: 24'($urandom);
			for (int i = 0; i < 125; i++) begin
				if (p == 3 && i == 40)
					hold_request = 1'b1;
				send_sample(next_frame_time());
			end
		end
		s_tvalid = 1'b0;
		no_idle  = 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d frame times over %0d window length writes, %0d long output stall(s)",
			samples_sent, length_writes, holds_done);
		$display("checked %0d averages, %0d of them with a clamped rate",
			board.results, board.clamped);
		if (board.errors == 0)
			$display("frame_time_moving_average_core_tb OK");
		else
			$display("frame_time_moving_average_core_tb NOT OK");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("timeout with %0d results outstanding", board.pending.size());
		$display("frame_time_moving_average_core_tb NOT OK");
		$finish;
	end

endmodule
